/* rtl/rtg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rtg_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 65536;
    localparam int unsigned RETRY_LIMIT_DEF  = 100;

    localparam int unsigned GEN_W  = 48;
    localparam int unsigned DIV_W  = 31;
    localparam int unsigned SEC_W  = 13;
    localparam int unsigned LEN_W  = 17;
    localparam int unsigned CHUNK_W = 16;
    localparam int unsigned MUL_W  = 35;

    localparam logic [MUL_W-1:0] LCG_MUL = 35'h5DEECE66D;
    localparam logic [GEN_W-1:0] LCG_ADD = 48'hB;

    typedef enum logic [1:0] {
        ACT_RESEED = 2'd0,
        ACT_LENGTH = 2'd1,
        ACT_BLOCK  = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_SECTOR = 2'd0,
        REG_MAX    = 2'd1,
        REG_MIN    = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FALLBACK = 2'd1,
        STS_INVALID  = 2'd2,
        STS_RSVD     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_WAIT,
        ST_MUL,
        ST_MOD,
        ST_MOD_WAIT,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* rtl/rtg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtg_div #(
    parameter int unsigned W = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* rtl/random_transfer_request_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake           | payload
// in       | in_valid / in_ready | action, seed_value, length_bytes
// out      | out_valid/out_ready | value, status
// cfg      | cfg_we              | cfg_index, cfg_data
//
// One request at a time. Each try: a 16x35 LCG multiply over 16-bit chunks of
// the state, then a 31-bit restoring divide for the modulo (shared divider).
// Draws first need a setup divide. A retry repeats the multiply and the modulo.
// Reseed and rejected requests go straight to the result.
// Reset clears the generator state to zero and the registers to defaults.
// in_ready stays low while a request is in work or its word waits to load out.
module random_transfer_request_generator
    import rtg_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = rtg_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned RETRY_LIMIT  = rtg_pkg::RETRY_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [47:0] seed_value,
    input  wire logic [16:0] length_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [30:0]      value,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);
    localparam int unsigned TW = $clog2(RETRY_LIMIT + 2);

    state_t state_reg, state_next;

    logic [SEC_W-1:0] sector_reg;
    logic [DIV_W-1:0] max_reg;
    logic [DIV_W-1:0] min_reg;

    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [GEN_W-1:0] acc_reg, acc_next;
    logic [1:0]       mcnt_reg, mcnt_next;
    logic [TW-1:0]    tries_reg, tries_next;
    logic [1:0]       act_reg, act_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W-1:0] need_reg, need_next;
    logic [DIV_W-1:0] span_reg, span_next;
    logic [DIV_W-1:0] res_val_reg, res_val_next;
    logic [1:0]       res_sts_reg, res_sts_next;
    logic             out_valid_reg, out_valid_next;
    logic [DIV_W-1:0] value_reg, value_next;
    logic [1:0]       status_reg, status_next;

    logic             div_start;
    logic             div_busy;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    logic                     in_acc;
    logic                     out_free;
    logic                     region_ok;
    logic                     sec_fits;
    logic                     fallback;
    logic [CHUNK_W-1:0]       chunk;
    logic [CHUNK_W+MUL_W-1:0] prod;
    logic [GEN_W-1:0]         term;
    logic [GEN_W-1:0]         acc_sum;
    logic [DIV_W-1:0]         m1;
    logic [DIV_W+SEC_W-1:0]   scaled;
    logic [DIV_W:0]           fit;
    logic                     len_ok;
    logic                     blk_ok;

    rtg_div #(.W(DIV_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign region_ok = max_reg > min_reg;
    assign sec_fits  = 32'(sector_reg) <= BUFFER_BYTES;
    assign fallback  = tries_reg > TW'(RETRY_LIMIT);

    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:    chunk = gen_reg[15:0];
            2'd1:    chunk = gen_reg[31:16];
            2'd2:    chunk = gen_reg[47:32];
            default: chunk = '0;
        endcase
        prod = {{CHUNK_W{1'b0}}, LCG_MUL} * {{MUL_W{1'b0}}, chunk};
        unique case (mcnt_reg)
            2'd0:    term = prod[GEN_W-1:0];
            2'd1:    term = {prod[GEN_W-17:0], 16'b0};
            2'd2:    term = {prod[GEN_W-33:0], 32'b0};
            default: term = '0;
        endcase
        acc_sum = acc_reg + term;
        m1      = (div_rem == '0) ? DIV_W'(1) : div_rem;
        scaled  = {{SEC_W{1'b0}}, div_rem} * {{DIV_W{1'b0}}, sector_reg};
        fit     = {1'b0, div_rem} + {1'b0, need_reg};
        len_ok  = sec_fits && (m1 <= max_reg);
        blk_ok  = fit < {1'b0, span_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (action == ACT_LENGTH && sector_reg != '0)
                        state_next = ST_PREP_WAIT;
                    else if (action == ACT_BLOCK && sector_reg != '0 && region_ok)
                        state_next = ST_PREP_WAIT;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_PREP_WAIT:
            begin
                if (!div_busy)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mcnt_reg == 2'd2)
                    state_next = fallback ? ST_DONE : ST_MOD;
            end
            ST_MOD:
                state_next = ST_MOD_WAIT;
            ST_MOD_WAIT:
            begin
                if (!div_busy)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((act_reg == ACT_LENGTH) ? len_ok : blk_ok)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        gen_next       = gen_reg;
        acc_next       = acc_reg;
        mcnt_next      = mcnt_reg;
        tries_next     = tries_reg;
        act_next       = act_reg;
        dvs_next       = dvs_reg;
        need_next      = need_reg;
        span_next      = span_reg;
        res_val_next   = res_val_reg;
        res_sts_next   = res_sts_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = DIV_W'(sector_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    act_next     = action;
                    tries_next   = TW'(1);
                    mcnt_next    = '0;
                    acc_next     = LCG_ADD;
                    res_val_next = '0;
                    res_sts_next = STS_INVALID;
                    span_next    = max_reg - min_reg;
                    priority if (action == ACT_RESEED)
                    begin
                        gen_next     = seed_value;
                        res_sts_next = STS_OK;
                    end
                    else if (action == ACT_LENGTH && sector_reg != '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(BUFFER_BYTES);
                    end
                    else if (action == ACT_BLOCK && sector_reg != '0 && region_ok)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(length_bytes);
                    end
                end
            end
            ST_PREP_WAIT:
            begin
                if (!div_busy)
                begin
                    dvs_next  = (act_reg == ACT_LENGTH) ? div_quo + 1'b1 : span_reg;
                    need_next = div_quo;
                end
            end
            ST_MUL:
            begin
                acc_next  = acc_sum;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd2)
                begin
                    gen_next  = acc_sum;
                    acc_next  = LCG_ADD;
                    mcnt_next = '0;
                    if (fallback)
                    begin
                        if (act_reg == ACT_LENGTH)
                        begin
                            if (max_reg != '0 && sec_fits)
                            begin
                                res_val_next = DIV_W'(sector_reg);
                                res_sts_next = STS_FALLBACK;
                            end
                        end
                        else if (need_reg < span_reg)
                        begin
                            res_val_next = min_reg;
                            res_sts_next = STS_FALLBACK;
                        end
                    end
                end
            end
            ST_MOD:
            begin
                div_start    = 1'b1;
                div_dividend = gen_reg[GEN_W-1:GEN_W-DIV_W];
                div_divisor  = dvs_reg;
            end
            ST_MOD_WAIT:
            begin
            end
            ST_CHECK:
            begin
                tries_next = tries_reg + 1'b1;
                if (act_reg == ACT_LENGTH)
                begin
                    if (len_ok)
                    begin
                        res_val_next = (div_rem == '0) ? DIV_W'(sector_reg)
                                                       : scaled[DIV_W-1:0];
                        res_sts_next = STS_OK;
                    end
                end
                else if (blk_ok)
                begin
                    res_val_next = div_rem + min_reg;
                    res_sts_next = STS_OK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_val_reg;
                    status_next    = res_sts_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gen_reg       <= '0;
            sector_reg    <= SEC_W'(2048);
            max_reg       <= DIV_W'(1000);
            min_reg       <= '0;
            tries_reg     <= '0;
            mcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            gen_reg       <= gen_next;
            tries_reg     <= tries_next;
            mcnt_reg      <= mcnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SECTOR: sector_reg <= cfg_data[SEC_W-1:0];
                    REG_MAX:    max_reg    <= cfg_data;
                    REG_MIN:    min_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        act_reg     <= act_next;
        dvs_reg     <= dvs_next;
        need_reg    <= need_next;
        span_reg    <= span_next;
        res_val_reg <= res_val_next;
        res_sts_reg <= res_sts_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tries_reg <= TW'(RETRY_LIMIT + 1))
        else $error("try count beyond limit");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STS_INVALID) |-> value == '0)
        else $error("invalid result with nonzero value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after accept");

endmodule
`default_nettype wire

/* dv/tb_random_transfer_request_generator.sv */
`timescale 1ns / 1ps
module tb_random_transfer_request_generator;
    import rtg_pkg::*;

    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned LEN_SPAN = 65536;
    localparam int TRY_MAX = 100;

    typedef struct packed {
        action_t     act;
        logic [47:0] seed;
        logic [16:0] len;
    } request_t;

    typedef struct packed {
        logic [30:0] value;
        status_t     st;
    } answer_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  action = ACT_RESEED;
    logic [47:0] seed_value = '0;
    logic [16:0] length_bytes = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [30:0] value;
    logic [1:0]  status;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = REG_SECTOR;
    logic [30:0] cfg_data = '0;

    request_t request_q[$];
    answer_t  answer_q[$];
    int       n_accepted = 0;
    int       n_errors = 0;

    longint unsigned lcg_x;
    longint unsigned sector_sz;
    longint unsigned hi_block;
    longint unsigned lo_block;

    random_transfer_request_generator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .seed_value(seed_value), .length_bytes(length_bytes),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned lcg_advance();
        lcg_x = (lcg_x * 64'h5DEECE66D + 64'hB) & MASK48;
        return lcg_x >> 17;
    endfunction

    function automatic bit length_fits(longint unsigned d);
        return d <= LEN_SPAN && d / sector_sz <= hi_block;
    endfunction

    function automatic answer_t predict_request(request_t r);
        answer_t a;
        longint unsigned q, d, span, need, b;
        a.value = '0;
        a.st = STS_INVALID;
        case (r.act)
            ACT_RESEED:
            begin
                lcg_x = r.seed;
                a.st = STS_OK;
            end
            ACT_LENGTH:
            begin
                if (sector_sz != 0)
                begin
                    q = LEN_SPAN / sector_sz + 1;
                    for (int t = 1; ; t++)
                    begin
                        d = lcg_advance() % q;
                        d = (d == 0) ? sector_sz : d * sector_sz;
                        if (t > TRY_MAX)
                        begin
                            if (length_fits(sector_sz))
                            begin
                                a.value = 31'(sector_sz);
                                a.st = STS_FALLBACK;
                            end
                            break;
                        end
                        if (length_fits(d))
                        begin
                            a.value = 31'(d);
                            a.st = STS_OK;
                            break;
                        end
                    end
                end
            end
            ACT_BLOCK:
            begin
                if (sector_sz != 0 && hi_block > lo_block)
                begin
                    span = hi_block - lo_block;
                    need = r.len / sector_sz;
                    for (int t = 1; ; t++)
                    begin
                        b = lcg_advance() % span;
                        if (t > TRY_MAX)
                        begin
                            if (need < span)
                            begin
                                a.value = 31'(lo_block);
                                a.st = STS_FALLBACK;
                            end
                            break;
                        end
                        if (b + need < span)
                        begin
                            a.value = 31'(b + lo_block);
                            a.st = STS_OK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic bit gap_now();
        if (n_accepted >= 500 && n_accepted < 750)
            return 0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                answer_q.push_back(predict_request(
                    '{act: action_t'(action), seed: seed_value, len: length_bytes}));
                n_accepted++;
            end
            if (request_q.size() > 0 && !gap_now())
            begin
                request_t r;
                r = request_q.pop_front();
                in_valid <= 1;
                action <= r.act;
                seed_value <= r.seed;
                length_bytes <= r.len;
            end
            else
            begin
                in_valid <= 0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected word: value=%0d status=%0d", value, status);
                end
                else
                begin
                    answer_t e;
                    e = answer_q.pop_front();
                    if (value !== e.value || status !== e.st)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                     e.value, value, e.st, status);
                    end
                end
            end
            out_ready <= !gap_now();
        end
    end

    task automatic push_req(action_t a, logic [47:0] s, logic [16:0] l);
        request_q.push_back('{act: a, seed: s, len: l});
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || in_valid || answer_q.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [30:0] d);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_SECTOR: sector_sz = d[12:0];
            REG_MAX:    hi_block = d;
            REG_MIN:    lo_block = d;
            default: ;
        endcase
    endtask

    task automatic add_random(int n, int len_max);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            push_req(k < 8 ? ACT_RESEED : k < 12 ? ACT_UNUSED :
                     k < 56 ? ACT_LENGTH : ACT_BLOCK,
                     48'({$urandom, $urandom}), 17'($urandom_range(0, len_max)));
        end
    endtask

    initial
    begin
        logic [30:0] lo;
        lcg_x = 0;
        sector_sz = 2048;
        hi_block = 1000;
        lo_block = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // defaults, field extremes, unused action
        push_req(ACT_LENGTH, '0, '0);
        push_req(ACT_BLOCK, '0, 17'd65536);
        push_req(ACT_RESEED, '1, '0);
        push_req(ACT_LENGTH, '1, '1);
        push_req(ACT_BLOCK, '0, '0);
        push_req(ACT_UNUSED, '1, '1);
        push_req(ACT_RESEED, 48'h0, '0);
        push_req(ACT_BLOCK, '1, 17'd65536);
        wait_drained();

        // tiny region: rejections, fallback and failed fallback
        write_reg(REG_SECTOR, 31'd4096);
        write_reg(REG_MAX, 31'd1);
        push_req(ACT_LENGTH, '0, '0);
        push_req(ACT_LENGTH, '0, '0);
        push_req(ACT_BLOCK, '0, 17'd0);
        push_req(ACT_BLOCK, '0, 17'd4096);
        push_req(ACT_BLOCK, '0, 17'd65536);
        wait_drained();

        // zero sector size
        write_reg(REG_SECTOR, 31'd0);
        push_req(ACT_LENGTH, '0, '0);
        push_req(ACT_BLOCK, '0, 17'd100);
        wait_drained();

        // empty region, then the top of the block range
        write_reg(REG_SECTOR, 31'd1);
        write_reg(REG_MIN, 31'd10);
        write_reg(REG_MAX, 31'd5);
        push_req(ACT_BLOCK, '0, '0);
        push_req(ACT_LENGTH, '0, '0);
        wait_drained();
        write_reg(REG_MAX, 31'h7FFF_FFFF);
        write_reg(REG_MIN, 31'h7FFF_FFFE);
        push_req(ACT_BLOCK, 48'h0, 17'd0);
        push_req(ACT_BLOCK, 48'h0, 17'd0);
        push_req(ACT_LENGTH, '0, '0);
        wait_drained();

        write_reg(REG_MIN, 31'd0);
        add_random(290, 65536);
        wait_drained();

        write_reg(REG_SECTOR, 31'd4096);
        write_reg(REG_MAX, 31'd3);
        add_random(290, 12287);
        wait_drained();

        for (int p = 0; p < 2; p++)
        begin
            lo = 31'($urandom_range(0, 31'h4000_0000));
            write_reg(REG_SECTOR, p == 0 ? 31'($urandom_range(1, 4096)) : 31'd512);
            write_reg(REG_MIN, lo);
            write_reg(REG_MAX, 31'(lo + $urandom_range(31'h10_0000, 31'h3FFF_FFFF)));
            add_random(290, 65536);
            wait_drained();
        end

        write_reg(REG_SECTOR, 31'd2048);
        write_reg(REG_MAX, 31'd1000);
        write_reg(REG_MIN, 31'd0);
        add_random(290, 65536);
        wait_drained();
        repeat (50) @(posedge clk);

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
